FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// holds every cycle outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/stt_pkg.sv
package stt_pkg;

  localparam int RowW = 5;
  localparam int ColW = 5;
  localparam int ValW = 32;
  localparam int CfgW = 6;
  localparam logic [CfgW-1:0] NumColsReset = 6'd32;

  typedef struct packed {
    logic [RowW-1:0]        src_row;
    logic [ColW-1:0]        src_col;
    logic signed [ValW-1:0] entry_value;
    logic                   is_last;
  } in_item_t;

  typedef struct packed {
    logic [ColW-1:0]        out_row;
    logic [RowW-1:0]        out_col;
    logic signed [ValW-1:0] out_value;
    logic                   out_last;
    logic                   error_flag;
  } out_item_t;

  // one stored triple
  typedef struct packed {
    logic [ColW-1:0] row;
    logic [ColW-1:0] col;
    logic [ValW-1:0] val;
  } trip_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREFIX,
    ST_SCATTER,
    ST_EMIT
  } stt_state_e;

  typedef struct packed {
    logic load;
    logic prefix;
    logic scatter;
    logic emit;
    logic idx_clr;
    logic clear;
  } stt_cmd_t;

  typedef struct packed {
    logic last_acc;
    logic none_kept;
    logic prefix_done;
    logic scatter_done;
    logic emit_done;
  } stt_sts_t;

endpackage

FILE: sv/stt_ctrl.sv
module stt_ctrl import stt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  stt_sts_t sts_i,
  output stt_cmd_t cmd_o,
  output logic     in_stall_o
);

  stt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        if (sts_i.last_acc) begin
          // empty matrix ends with no results
          if (sts_i.none_kept) begin
            cmd_o.clear = 1'b1;
          end else begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_PREFIX;
          end
        end
      end
      ST_PREFIX: begin
        cmd_o.prefix = 1'b1;
        if (sts_i.prefix_done) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_SCATTER;
        end
      end
      ST_SCATTER: begin
        cmd_o.scatter = 1'b1;
        if (sts_i.scatter_done) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_done) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_LOAD);

endmodule

FILE: sv/stt_datapath.sv
module stt_datapath import stt_pkg::*; #(
  parameter int MAX_DIM  = 32,
  parameter int CAPACITY = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stt_cmd_t        cmd_i,
  output stt_sts_t        sts_o,
  input  logic            in_valid_i,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  // source columns never exceed the column field range
  localparam int CntDepth = MAX_DIM < (2 ** ColW) ? MAX_DIM : (2 ** ColW);
  localparam int CntW     = $clog2(CntDepth);
  localparam int PosW     = $clog2(CAPACITY + 1);
  localparam int AddrW    = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
  localparam int IdxMax   = CAPACITY > CntDepth ? CAPACITY : CntDepth;
  localparam int IdxW     = $clog2(IdxMax + 1);

  logic [CfgW-1:0] num_cols_q;
  logic [PosW-1:0] entry_cnt_q;
  logic            dropped_q;
  logic [PosW-1:0] cnt_q [CntDepth];
  logic [PosW-1:0] acc_q;
  logic [IdxW-1:0] idx_q;
  logic            sc_v_q;
  logic            out_v_q;
  logic            olast_q;
  trip_t           trd_q;
  trip_t           ord_q;
  trip_t           tstore [CAPACITY];
  trip_t           ostore [CAPACITY];

  logic            accept;
  logic            col_ok;
  logic            full;
  logic            keep;
  logic [CntW-1:0] cnt_addr;
  logic [PosW-1:0] cnt_rd;
  logic [IdxW-1:0] n_ext;
  logic            sc_issue;
  logic            rd_en;
  logic            out_acc;

  assign cfg_ready_o = 1'b1;

  assign accept = cmd_i.load && in_valid_i;
  assign col_ok = ({1'b0, in_item_i.src_col} < num_cols_q) &&
                  (int'(in_item_i.src_col) < MAX_DIM);
  assign full   = (entry_cnt_q == PosW'(CAPACITY));
  assign keep   = accept && col_ok && !full;
  assign n_ext  = IdxW'(entry_cnt_q);

  // single port on the column counts, address chosen by phase
  always_comb begin
    if (cmd_i.load) begin
      cnt_addr = in_item_i.src_col[CntW-1:0];
    end else if (cmd_i.prefix) begin
      cnt_addr = idx_q[CntW-1:0];
    end else begin
      cnt_addr = trd_q.row[CntW-1:0];
    end
  end
  assign cnt_rd = cnt_q[cnt_addr];

  assign sc_issue = cmd_i.scatter && (idx_q < n_ext);
  assign out_acc  = out_v_q && !out_stall_i;
  assign rd_en    = cmd_i.emit && (idx_q < n_ext) && (!out_v_q || !out_stall_i);

  assign sts_o.last_acc     = accept && in_item_i.is_last;
  assign sts_o.none_kept    = (entry_cnt_q == '0) && !keep;
  assign sts_o.prefix_done  = cmd_i.prefix && (idx_q == IdxW'(CntDepth - 1));
  assign sts_o.scatter_done = cmd_i.scatter && !sc_issue && !sc_v_q;
  assign sts_o.emit_done    = out_acc && olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= NumColsReset;
    end else if (cfg_valid_i) begin
      num_cols_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_cnt_q <= '0;
      dropped_q   <= 1'b0;
      acc_q       <= '0;
      idx_q       <= '0;
      sc_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      for (int i = 0; i < CntDepth; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      sc_v_q <= sc_issue;
      if (rd_en) begin
        out_v_q <= 1'b1;
      end else if (out_acc) begin
        out_v_q <= 1'b0;
      end

      if (cmd_i.idx_clr) begin
        idx_q <= '0;
        acc_q <= '0;
      end else if (cmd_i.prefix || sc_issue || rd_en) begin
        idx_q <= idx_q + 1'b1;
      end

      if (cmd_i.clear) begin
        entry_cnt_q <= '0;
        dropped_q   <= 1'b0;
        for (int i = 0; i < CntDepth; i++) begin
          cnt_q[i] <= '0;
        end
      end else begin
        if (accept && !keep) begin
          dropped_q <= 1'b1;
        end
        if (keep) begin
          entry_cnt_q      <= entry_cnt_q + 1'b1;
          cnt_q[cnt_addr]  <= cnt_rd + 1'b1;
        end else if (cmd_i.prefix) begin
          // counts become exclusive start offsets in place
          cnt_q[cnt_addr] <= acc_q;
          if (!cmd_i.idx_clr) begin
            acc_q <= acc_q + cnt_rd;
          end
        end else if (cmd_i.scatter && sc_v_q) begin
          cnt_q[cnt_addr] <= cnt_rd + 1'b1;
        end
      end
    end
  end

  // stores and payload registers
  always_ff @(posedge clk_i) begin
    if (keep) begin
      tstore[entry_cnt_q[AddrW-1:0]] <= '{row: in_item_i.src_col,
                                          col: in_item_i.src_row,
                                          val: in_item_i.entry_value};
    end
    if (sc_issue) begin
      trd_q <= tstore[idx_q[AddrW-1:0]];
    end
    if (cmd_i.scatter && sc_v_q) begin
      ostore[cnt_rd[AddrW-1:0]] <= trd_q;
    end
    if (rd_en) begin
      ord_q   <= ostore[idx_q[AddrW-1:0]];
      olast_q <= ((idx_q + 1'b1) == n_ext);
    end
  end

  assign out_valid_o           = out_v_q;
  assign out_item_o.out_row    = ord_q.row;
  assign out_item_o.out_col    = ord_q.col;
  assign out_item_o.out_value  = ord_q.val;
  assign out_item_o.out_last   = olast_q;
  assign out_item_o.error_flag = dropped_q;

endmodule

FILE: sv/sparse_triple_transpose_unit.sv
// Sparse matrix transpose on (row, column, value) triples. Triples load at one item per
// cycle while the input is not stalled; each is kept in a store of CAPACITY entries and
// counted per column, and one with a column at or beyond num_cols or MAX_DIM (or arriving
// on a full store) is dropped and raises error_flag on the results. The item marked last
// ends the matrix: the block then stalls its input for prefix sums over min(MAX_DIM, 32)
// column counts, a scatter through the store's registered read port, and the emit phase,
// which streams one transposed triple per cycle while the output is not stalled, ordered by
// new row and in source order within a row, with out_last on the final one. A matrix with
// no kept triple gives no result. An output stall holds the result.
module sparse_triple_transpose_unit import stt_pkg::*; #(
  parameter int MAX_DIM  = 32,
  parameter int CAPACITY = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  stt_cmd_t cmd;
  stt_sts_t sts;

  stt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  stt_datapath #(
    .MAX_DIM  (MAX_DIM),
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

FILE: sv/stt_checker.sv
`include "assert_macros.svh"

module stt_checker import stt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // no item is taken while results are pending
  `ASSERT_ALWAYS(a_no_load_while_emit, clk_i, rst_ni, !out_valid_o || in_stall_o)

  // the final result closes the matrix
  `ASSERT_NEXT(a_idle_after_last, clk_i, rst_ni,
               out_valid_o && !out_stall_i && out_item_o.out_last, !out_valid_o)

  `ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `ASSERT_NEXT(a_payload_holds, clk_i, rst_ni,
               out_valid_o && out_stall_i, $stable(out_item_o))

endmodule

bind sparse_triple_transpose_unit stt_checker u_stt_checker (.*);
